[src/rvmd_pkg.sv]
// ----------------------------------------------------------------------------
// rvmd_pkg: shared types and constants of the RV64M multiply/divide unit
// Operation codes, word widths and the record that moves down the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package rvmd_pkg;
  localparam int unsigned XLEN  = 64;
  localparam int unsigned CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_MUL    = 3'd0,
    CMD_MULH   = 3'd1,
    CMD_MULHSU = 3'd2,
    CMD_MULHU  = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_DIVU   = 3'd5,
    CMD_REM    = 3'd6,
    CMD_REMU   = 3'd7
  } cmd_e;

  // Record carried from cell to cell.
  // Multiply: acc holds the 128-bit running product, mb the unshifted multiplicand.
  // Divide: acc[127:64] partial remainder, acc[63:0] dividend bits / quotient bits.
  typedef struct packed {
    logic                 vld;
    cmd_e                 cmd;
    logic [XLEN-1:0]      a;      // original op_a
    logic [XLEN-1:0]      b;      // original op_b
    logic [XLEN-1:0]      ma;     // multiplier op_b (mul) or op_a (div)
    logic [XLEN-1:0]      mb;     // multiplicand or |divisor|
    logic [2*XLEN-1:0]    acc;
  } stage_t;
endpackage
`default_nettype wire

[src/rvmd_if.sv]
// ----------------------------------------------------------------------------
// rvmd_if: valid/ready channel carrying a payload of a given type
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface rvmd_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/rvmd_cell.sv]
// ----------------------------------------------------------------------------
// rvmd_cell: one step of the chain
// Handles one bit of the multiplier (shift-add) or one quotient bit
// (restoring division) and hands the record to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module rvmd_cell import rvmd_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire stage_t s_i,
  output stage_t      s_o
);
  stage_t          n;
  logic [XLEN:0]   rem_sh;
  logic [XLEN:0]   diff;
  logic [2*XLEN-1:0] addend;

  always_comb begin
    n      = s_i;
    rem_sh = {s_i.acc[2*XLEN-1:XLEN], s_i.acc[XLEN-1]};
    diff   = rem_sh - {1'b0, s_i.mb};
    addend = {{XLEN{1'b0}}, s_i.mb} << Idx;
    if (s_i.cmd[2]) begin
      if (!diff[XLEN]) begin
        n.acc = {diff[XLEN-1:0], s_i.acc[XLEN-2:0], 1'b1};
      end else begin
        n.acc = {rem_sh[XLEN-1:0], s_i.acc[XLEN-2:0], 1'b0};
      end
    end else if (s_i.ma[Idx]) begin
      n.acc = s_i.acc + addend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_o <= '0;
    end else if (en_i) begin
      s_o <= n;
    end
  end
endmodule
`default_nettype wire

[src/rv64_mul_div_unit_top.sv]
// ----------------------------------------------------------------------------
// rv64_mul_div_unit_top: RV64M multiply/divide unit
// Operations enter on in_if (cmd, op_a, op_b) and leave on out_if (result).
// A transaction is accepted when valid and ready are both high.
// The datapath is a chain of 64 cells: each cell retires one multiplier
// bit (shift-add) or one quotient bit (restoring division). An entry
// register prepares operands (magnitudes for divide), the cells follow,
// and an exit register applies signs and special cases. A new transaction
// may enter every cycle unless the chain is stalled; up to 66 are in flight.
// The whole chain advances together; when the receiver stalls with a
// result waiting, the chain holds and in_if.ready drops, otherwise it
// keeps moving even with a result pending in the output register.
// Reset clears every register of the entry stage and the cell chain.
// Zero divisor gives all ones (div/divu) or the dividend (rem/remu);
// the most negative value divided by -1 gives the dividend and zero.
// ----------------------------------------------------------------------------
`default_nettype none
module rv64_mul_div_unit_top import rvmd_pkg::*; #(
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rvmd_if.sink      in_if,
  rvmd_if.source    out_if
);
  localparam int unsigned NCELL = XLEN;

  stage_t chain [NCELL+1];
  logic   adv;
  logic   out_vld_q;
  logic [XLEN-1:0] out_res_q;
  logic [XLEN-1:0] res_d;

  // payload fields of in_if.data: cmd, op_a, op_b
  cmd_e            in_cmd;
  logic [XLEN-1:0] in_a, in_b;
  logic            a_neg, b_neg, sdiv;

  assign in_cmd = cmd_e'(in_if.data.cmd);
  assign in_a   = in_if.data.op_a;
  assign in_b   = in_if.data.op_b;

  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = adv;

  stage_t entry_d, entry_q;
  always_comb begin
    sdiv          = (in_cmd == CMD_DIV) || (in_cmd == CMD_REM);
    a_neg         = sdiv && in_a[XLEN-1];
    b_neg         = sdiv && in_b[XLEN-1];
    entry_d.vld   = in_if.valid;
    entry_d.cmd   = in_cmd;
    entry_d.a     = in_a;
    entry_d.b     = in_b;
    if (in_cmd[2]) begin
      entry_d.ma  = in_a;
      entry_d.mb  = b_neg ? (~in_b + 1'b1) : in_b;
      entry_d.acc = {{XLEN{1'b0}}, a_neg ? (~in_a + 1'b1) : in_a};
    end else begin
      entry_d.ma  = in_b;
      entry_d.mb  = in_a;
      entry_d.acc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (adv) begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    rvmd_cell #(.Idx(i)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .s_i    (chain[i]),
      .s_o    (chain[i+1])
    );
  end

  stage_t          fin;
  logic [XLEN-1:0] q, r, hi;
  logic            an, bn, bz, ovf;

  always_comb begin
    fin = chain[NCELL];
    q   = fin.acc[XLEN-1:0];
    r   = fin.acc[2*XLEN-1:XLEN];
    hi  = fin.acc[2*XLEN-1:XLEN];
    an  = fin.a[XLEN-1];
    bn  = fin.b[XLEN-1];
    bz  = (fin.b == '0);
    ovf = (fin.a == {1'b1, {(XLEN-1){1'b0}}}) && (fin.b == '1);
    unique case (fin.cmd)
      CMD_MUL:    res_d = fin.acc[XLEN-1:0];
      CMD_MULH:   res_d = hi - (an ? fin.b : '0) - (bn ? fin.a : '0);
      CMD_MULHSU: res_d = hi - (an ? fin.b : '0);
      CMD_MULHU:  res_d = hi;
      CMD_DIV: begin
        if (bz)       res_d = '1;
        else if (ovf) res_d = fin.a;
        else          res_d = (an ^ bn) ? (~q + 1'b1) : q;
      end
      CMD_DIVU:   res_d = bz ? '1 : q;
      CMD_REM: begin
        if (bz)       res_d = fin.a;
        else if (ovf) res_d = '0;
        else          res_d = an ? (~r + 1'b1) : r;
      end
      default:    res_d = bz ? fin.a : r;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= fin.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.data.result = out_res_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_if.ready) |=> $stable(out_res_q))
    else $error("result changed under stall");
  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready does not follow output side");
  a_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> entry_q.vld)
    else $error("accepted transaction missing from entry register");
endmodule
`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression for the RV64M multiply/divide unit
// Drives cmd/op_a/op_b transactions with random gaps and receiver stalls,
// predicts each result and checks every output transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import rvmd_pkg::*;

  typedef struct packed {
    cmd_e            cmd;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;
  } req_t;

  typedef struct packed {
    logic [XLEN-1:0] result;
  } rsp_t;

  localparam logic [XLEN-1:0] MIN_NEG  = {1'b1, {(XLEN-1){1'b0}}};
  localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};
  localparam int unsigned     CYCLE_LIMIT = 400000;
  localparam int unsigned     DRAIN_CYCLES = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rvmd_if #(.T(req_t)) in_if ();
  rvmd_if #(.T(rsp_t)) out_if ();

  rv64_mul_div_unit_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  logic [XLEN-1:0] result_q[$];
  int unsigned     errors = 0;
  int unsigned     cycles = 0;
  bit              burst = 1'b0;
  bit              stall_req = 1'b0;

  always #5 clk_i = ~clk_i;

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    out_if.ready = 1'b0;
  end

  function automatic logic [XLEN-1:0] muldiv(cmd_e cmd, logic [XLEN-1:0] a,
                                            logic [XLEN-1:0] b);
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0]   r;
    r = '0;
    case (cmd)
      CMD_MUL: begin
        prod = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
        r = prod[XLEN-1:0];
      end
      CMD_MULH: begin
        prod = {{XLEN{a[XLEN-1]}}, a} * {{XLEN{b[XLEN-1]}}, b};
        r = prod[2*XLEN-1:XLEN];
      end
      CMD_MULHSU: begin
        prod = {{XLEN{a[XLEN-1]}}, a} * {{XLEN{1'b0}}, b};
        r = prod[2*XLEN-1:XLEN];
      end
      CMD_MULHU: begin
        prod = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
        r = prod[2*XLEN-1:XLEN];
      end
      CMD_DIV: begin
        if (b == '0) r = ALL_ONES;
        else if (a == MIN_NEG && b == ALL_ONES) r = a;
        else r = $signed(a) / $signed(b);
      end
      CMD_DIVU: r = (b == '0) ? ALL_ONES : a / b;
      CMD_REM: begin
        if (b == '0) r = a;
        else if (a == MIN_NEG && b == ALL_ONES) r = '0;
        else r = $signed(a) % $signed(b);
      end
      default: r = (b == '0) ? a : a % b;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic send_op(cmd_e cmd, logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    @(negedge clk_i);
    repeat (gap) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.data  = '{cmd: cmd, op_a: a, op_b: b};
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    result_q.push_back(muldiv(cmd, a, b));
  endtask

  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return MIN_NEG;
      4: return MIN_NEG - 1;
      5: return 64'($urandom_range(0, 255));
      6: return -64'($urandom_range(1, 255));
      7: return {32'd0, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  // sink: random ready gaps, one long hold when requested
  initial begin : sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        gap = 400;
        stall_req = 1'b0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end
      repeat (gap) begin
        out_if.ready = 1'b0;
        @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (result_q.size() == 0) report("unexpected", out_if.data.result, '0);
      else if (out_if.data.result !== result_q[0]) begin
        report("result", out_if.data.result, result_q[0]);
        void'(result_q.pop_front());
      end else void'(result_q.pop_front());
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_directed();
    logic [XLEN-1:0] vals[6];
    vals = '{64'd0, 64'd1, ALL_ONES, MIN_NEG, MIN_NEG - 1, 64'd7};
    for (int c = 0; c < 8; c++) send_op(cmd_e'(c), MIN_NEG, ALL_ONES);
    for (int c = 4; c < 8; c++) send_op(cmd_e'(c), 64'h1234_5678_9abc_def0, '0);
    send_op(CMD_MULH, MIN_NEG, MIN_NEG);
    send_op(CMD_MULHSU, MIN_NEG, ALL_ONES);
    send_op(CMD_MULHU, ALL_ONES, ALL_ONES);
    send_op(CMD_MUL, ALL_ONES, ALL_ONES);
    for (int i = 0; i < 6; i++) send_op(cmd_e'($urandom_range(0, 7)), vals[i], vals[5-i]);
    send_op(CMD_REM, -64'd7, 64'd2);
    send_op(CMD_DIV, -64'd7, 64'd2);
  endtask

  task automatic test_random_mul(int unsigned n);
    repeat (n) send_op(cmd_e'($urandom_range(0, 3)), pick_operand(), pick_operand());
  endtask

  task automatic test_random_div(int unsigned n);
    repeat (n) send_op(cmd_e'($urandom_range(4, 7)), pick_operand(), pick_operand());
  endtask

  task automatic test_backpressure(int unsigned n);
    burst = 1'b1;
    stall_req = 1'b1;
    repeat (n) send_op(cmd_e'($urandom_range(0, 7)), pick_operand(), pick_operand());
    burst = 1'b0;
  endtask

  task automatic test_mixed(int unsigned n);
    repeat (n) send_op(cmd_e'($urandom_range(0, 7)),
                       {32'($urandom), 32'($urandom)}, {32'($urandom), 32'($urandom)});
  endtask

  initial begin : stim
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_mul(200);
    test_random_div(200);
    test_backpressure(150);
    test_mixed(150);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
`default_nettype wire

[rv64_mul_div_unit_top.f]
src/rvmd_pkg.sv
src/rvmd_if.sv
src/rvmd_cell.sv
src/rv64_mul_div_unit_top.sv
test/testbench.sv
